@@ src/tls_sni_pkg.sv @@
package tls_sni_pkg;

	localparam int unsigned LENGTH_BITS = 16;

	localparam logic [7:0] CT_HANDSHAKE    = 8'h16;
	localparam logic [7:0] CT_APPDATA      = 8'h17;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;

	localparam logic [LENGTH_BITS-1:0] MIN_RECORD_LEN = LENGTH_BITS'(6);
	localparam logic [LENGTH_BITS-1:0] HS_BODY_POS    = LENGTH_BITS'(9);
	localparam logic [LENGTH_BITS-1:0] POS_MAX        = '1;

	// skip counts loaded on the first byte (position 0)
	localparam logic [15:0] HST_SKIP = 16'd4;
	localparam logic [15:0] APP_SKIP = 16'd2;

	// first byte after handshake header, version and random (9 + 34)
	localparam logic [17:0] SID_POS = 18'd43;

	localparam logic [4:0] PH_IDLE   = 5'd0;
	localparam logic [4:0] PH_OFF    = 5'd1;
	localparam logic [4:0] PH_APP_HI = 5'd2;
	localparam logic [4:0] PH_APP_LO = 5'd3;
	localparam logic [4:0] PH_HST    = 5'd4;
	localparam logic [4:0] PH_SID    = 5'd5;
	localparam logic [4:0] PH_CS_HI  = 5'd6;
	localparam logic [4:0] PH_CS_LO  = 5'd7;
	localparam logic [4:0] PH_CM     = 5'd8;
	localparam logic [4:0] PH_EXL_HI = 5'd9;
	localparam logic [4:0] PH_EXL_LO = 5'd10;
	localparam logic [4:0] PH_ET_HI  = 5'd11;
	localparam logic [4:0] PH_ET_LO  = 5'd12;
	localparam logic [4:0] PH_EL_HI  = 5'd13;
	localparam logic [4:0] PH_EL_LO  = 5'd14;
	localparam logic [4:0] PH_NTYPE  = 5'd15;
	localparam logic [4:0] PH_NL_HI  = 5'd16;
	localparam logic [4:0] PH_NL_LO  = 5'd17;
	localparam logic [4:0] PH_NAME   = 5'd18;

	localparam logic [1:0] CLASS_NONE = 2'd0;
	localparam logic [1:0] CLASS_HS   = 2'd1;
	localparam logic [1:0] CLASS_APP  = 2'd2;

	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  name_byte;
		logic        name_end;
		logic [1:0]  record_class;
		logic [15:0] app_record_length;
		logic        sni_found;
		logic [15:0] sni_length;
	} result_t;

	typedef struct packed {
		logic    name_vld;
		logic    summary_vld;
		result_t name_res;
		result_t summary_res;
	} push_t;

endpackage

@@ src/tls_sni_parser.sv @@
module tls_sni_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_valid,
	output logic                       byte_stall,
	input  logic [7:0]                 data_byte,
	input  logic [15:0]                packet_length,
	input  logic                       last_byte,
	input  logic                       push_ready,
	output tls_sni_pkg::push_t         push
);

	logic        s1_valid_q;
	logic [7:0]  data_s1;
	logic [15:0] len_s1;
	logic        last_s1;
	logic        accept;
	logic        proc;

	logic [tls_sni_pkg::LENGTH_BITS-1:0] pos_q, pos_n;
	logic [tls_sni_pkg::LENGTH_BITS-1:0] held_len_q, held_len_n;
	logic [4:0]  phase_q, phase_n;
	logic [15:0] skip_q, skip_n;
	logic [16:0] ext_end_q, ext_end_n;
	logic [7:0]  acc_q, acc_n;
	logic        ext_zero_q, ext_zero_n;
	logic [15:0] name_rem_q, name_rem_n;
	logic [1:0]  class_q, class_n;
	logic [15:0] rec_len_q, rec_len_n;
	logic        found_q, found_n;
	logic [15:0] name_len_q, name_len_n;

	logic [16:0] p;
	logic [17:0] p18;
	logic [15:0] v;
	logic [17:0] pv;
	logic [17:0] pd;
	logic [15:0] nr_dec;
	logic [tls_sni_pkg::LENGTH_BITS-1:0] len_in;

	logic        nf_req;
	logic [17:0] nf_p;
	logic [2:0]  nf_need;
	logic [16:0] nf_bound;
	logic [4:0]  nf_phase;
	logic [17:0] nf_end;
	logic [17:0] nf_skip;

	logic        name_vld;
	logic        name_end_bit;

	assign accept     = byte_valid && !byte_stall;
	assign proc       = s1_valid_q && push_ready;
	assign byte_stall = s1_valid_q && !push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (proc) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			len_s1  <= packet_length;
			last_s1 <= last_byte;
		end
	end

	assign len_in = len_s1[tls_sni_pkg::LENGTH_BITS-1:0];
	assign p      = {1'b0, pos_q} + 17'd1;
	assign p18    = {1'b0, p};
	assign v      = {acc_q, data_s1};
	assign pv     = p18 + {2'b0, v};
	assign pd     = p18 + {10'b0, data_s1};
	assign nr_dec = name_rem_q - 16'd1;

	always_comb begin
		pos_n      = pos_q;
		held_len_n = held_len_q;
		phase_n    = phase_q;
		skip_n     = skip_q;
		ext_end_n  = ext_end_q;
		acc_n      = acc_q;
		ext_zero_n = ext_zero_q;
		name_rem_n = name_rem_q;
		class_n    = class_q;
		rec_len_n  = rec_len_q;
		found_n    = found_q;
		name_len_n = name_len_q;

		nf_req       = 1'b0;
		nf_p         = p18;
		nf_need      = 3'd4;
		nf_bound     = ext_end_q;
		nf_phase     = tls_sni_pkg::PH_ET_HI;
		name_vld     = 1'b0;
		name_end_bit = 1'b0;

		if (phase_q == tls_sni_pkg::PH_IDLE) begin
			held_len_n = len_in;
			class_n    = tls_sni_pkg::CLASS_NONE;
			rec_len_n  = '0;
			found_n    = 1'b0;
			name_len_n = '0;
			skip_n     = '0;
			name_rem_n = '0;
			phase_n    = tls_sni_pkg::PH_OFF;
			if (len_in >= tls_sni_pkg::MIN_RECORD_LEN) begin
				if (data_s1 == tls_sni_pkg::CT_HANDSHAKE) begin
					class_n = tls_sni_pkg::CLASS_HS;
					if (len_in > tls_sni_pkg::HS_BODY_POS) begin
						skip_n  = tls_sni_pkg::HST_SKIP;
						phase_n = tls_sni_pkg::PH_HST;
					end
				end else if (data_s1 == tls_sni_pkg::CT_APPDATA) begin
					class_n = tls_sni_pkg::CLASS_APP;
					skip_n  = tls_sni_pkg::APP_SKIP;
					phase_n = tls_sni_pkg::PH_APP_HI;
				end
			end
			pos_n = tls_sni_pkg::LENGTH_BITS'(1);
		end else begin
			if (phase_q != tls_sni_pkg::PH_OFF && pos_q < held_len_q) begin
				if (skip_q != '0) begin
					skip_n = skip_q - 16'd1;
				end else begin
					unique case (phase_q)
						tls_sni_pkg::PH_APP_HI: begin
							acc_n   = data_s1;
							phase_n = tls_sni_pkg::PH_APP_LO;
						end
						tls_sni_pkg::PH_APP_LO: begin
							rec_len_n = v;
							phase_n   = tls_sni_pkg::PH_OFF;
						end
						tls_sni_pkg::PH_HST: begin
							if (data_s1 == tls_sni_pkg::HS_CLIENT_HELLO) begin
								nf_req   = 1'b1;
								nf_p     = tls_sni_pkg::SID_POS;
								nf_need  = 3'd1;
								nf_bound = {1'b0, held_len_q};
								nf_phase = tls_sni_pkg::PH_SID;
							end else begin
								phase_n = tls_sni_pkg::PH_OFF;
							end
						end
						tls_sni_pkg::PH_SID: begin
							nf_req   = 1'b1;
							nf_p     = pd;
							nf_need  = 3'd2;
							nf_bound = {1'b0, held_len_q};
							nf_phase = tls_sni_pkg::PH_CS_HI;
						end
						tls_sni_pkg::PH_CS_HI: begin
							acc_n   = data_s1;
							phase_n = tls_sni_pkg::PH_CS_LO;
						end
						tls_sni_pkg::PH_CS_LO: begin
							nf_req   = 1'b1;
							nf_p     = pv;
							nf_need  = 3'd1;
							nf_bound = {1'b0, held_len_q};
							nf_phase = tls_sni_pkg::PH_CM;
						end
						tls_sni_pkg::PH_CM: begin
							nf_req   = 1'b1;
							nf_p     = pd;
							nf_need  = 3'd2;
							nf_bound = {1'b0, held_len_q};
							nf_phase = tls_sni_pkg::PH_EXL_HI;
						end
						tls_sni_pkg::PH_EXL_HI: begin
							acc_n   = data_s1;
							phase_n = tls_sni_pkg::PH_EXL_LO;
						end
						tls_sni_pkg::PH_EXL_LO: begin
							// extensions end is clipped to the packet
							if (pv > {2'b0, held_len_q}) begin
								ext_end_n = {1'b0, held_len_q};
							end else begin
								ext_end_n = pv[16:0];
							end
							nf_req   = 1'b1;
							nf_p     = p18;
							nf_bound = ext_end_n;
						end
						tls_sni_pkg::PH_ET_HI: begin
							acc_n   = data_s1;
							phase_n = tls_sni_pkg::PH_ET_LO;
						end
						tls_sni_pkg::PH_ET_LO: begin
							ext_zero_n = (v == 16'd0);
							phase_n    = tls_sni_pkg::PH_EL_HI;
						end
						tls_sni_pkg::PH_EL_HI: begin
							acc_n   = data_s1;
							phase_n = tls_sni_pkg::PH_EL_LO;
						end
						tls_sni_pkg::PH_EL_LO: begin
							nf_req = 1'b1;
							if (ext_zero_q) begin
								nf_p     = p18 + 18'd2;
								nf_need  = 3'd1;
								nf_phase = tls_sni_pkg::PH_NTYPE;
							end else begin
								nf_p = pv;
							end
						end
						tls_sni_pkg::PH_NTYPE: begin
							nf_req = 1'b1;
							if (data_s1 == 8'd0) begin
								nf_need  = 3'd2;
								nf_phase = tls_sni_pkg::PH_NL_HI;
							end
						end
						tls_sni_pkg::PH_NL_HI: begin
							acc_n   = data_s1;
							phase_n = tls_sni_pkg::PH_NL_LO;
						end
						tls_sni_pkg::PH_NL_LO: begin
							if (pv <= {1'b0, ext_end_q}) begin
								if (v == 16'd0) begin
									phase_n = tls_sni_pkg::PH_OFF;
								end else begin
									name_rem_n = v;
									name_len_n = v;
									skip_n     = '0;
									phase_n    = tls_sni_pkg::PH_NAME;
								end
							end else begin
								// name does not fit: carry on with an extension header
								nf_req = 1'b1;
							end
						end
						tls_sni_pkg::PH_NAME: begin
							name_rem_n = nr_dec;
							name_vld   = 1'b1;
							if (nr_dec == 16'd0) begin
								found_n      = 1'b1;
								phase_n      = tls_sni_pkg::PH_OFF;
								name_end_bit = 1'b1;
							end
						end
						default: begin
							phase_n = tls_sni_pkg::PH_OFF;
						end
					endcase
				end
			end
			if (pos_q != tls_sni_pkg::POS_MAX) begin
				pos_n = pos_q + tls_sni_pkg::LENGTH_BITS'(1);
			end
		end

		nf_end  = nf_p + {15'b0, nf_need};
		nf_skip = nf_p - p18;

		if (nf_req) begin
			if (nf_end > {1'b0, nf_bound}) begin
				phase_n = tls_sni_pkg::PH_OFF;
			end else begin
				skip_n  = nf_skip[15:0];
				phase_n = nf_phase;
			end
		end

		if (last_s1) begin
			phase_n = tls_sni_pkg::PH_IDLE;
			pos_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			held_len_q <= '0;
			phase_q    <= tls_sni_pkg::PH_IDLE;
			skip_q     <= '0;
			ext_end_q  <= '0;
			acc_q      <= '0;
			ext_zero_q <= 1'b0;
			name_rem_q <= '0;
			class_q    <= tls_sni_pkg::CLASS_NONE;
			rec_len_q  <= '0;
			found_q    <= 1'b0;
			name_len_q <= '0;
		end else if (proc) begin
			pos_q      <= pos_n;
			held_len_q <= held_len_n;
			phase_q    <= phase_n;
			skip_q     <= skip_n;
			ext_end_q  <= ext_end_n;
			acc_q      <= acc_n;
			ext_zero_q <= ext_zero_n;
			name_rem_q <= name_rem_n;
			class_q    <= class_n;
			rec_len_q  <= rec_len_n;
			found_q    <= found_n;
			name_len_q <= name_len_n;
		end
	end

	always_comb begin
		push.name_vld    = proc && name_vld;
		push.summary_vld = proc && last_s1;

		push.name_res.item_kind         = tls_sni_pkg::KIND_NAME;
		push.name_res.name_byte         = data_s1;
		push.name_res.name_end          = name_end_bit;
		push.name_res.record_class      = tls_sni_pkg::CLASS_NONE;
		push.name_res.app_record_length = '0;
		push.name_res.sni_found         = 1'b0;
		push.name_res.sni_length        = '0;

		push.summary_res.item_kind    = tls_sni_pkg::KIND_SUMMARY;
		push.summary_res.name_byte    = '0;
		push.summary_res.name_end     = 1'b0;
		push.summary_res.record_class = class_n;
		push.summary_res.app_record_length =
			(class_n == tls_sni_pkg::CLASS_APP) ? rec_len_n : 16'd0;
		push.summary_res.sni_found  = found_n;
		push.summary_res.sni_length = found_n ? name_len_n : 16'd0;
	end

endmodule

@@ src/tls_sni_result_queue.sv @@
module tls_sni_result_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tls_sni_pkg::push_t   push,
	output logic                 push_ready,
	output logic                 head_valid,
	input  logic                 head_stall,
	output tls_sni_pkg::result_t head
);

	tls_sni_pkg::result_t entry_q [tls_sni_pkg::QUEUE_DEPTH];

	logic [tls_sni_pkg::QUEUE_AW-1:0] wr_q;
	logic [tls_sni_pkg::QUEUE_AW-1:0] rd_q;
	logic [tls_sni_pkg::QUEUE_AW:0]   count_q;
	logic [tls_sni_pkg::QUEUE_AW-1:0] wr_next;
	logic [1:0]                       n_push;
	logic                             pop;
	tls_sni_pkg::result_t             first_res;

	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_q];
	assign pop        = head_valid && !head_stall;
	assign push_ready = count_q <= (tls_sni_pkg::QUEUE_AW + 1)'(tls_sni_pkg::QUEUE_DEPTH - 2);
	assign n_push     = {1'b0, push.name_vld} + {1'b0, push.summary_vld};
	assign first_res  = push.name_vld ? push.name_res : push.summary_res;
	assign wr_next    = wr_q + tls_sni_pkg::QUEUE_AW'(1);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			entry_q[wr_q] <= first_res;
		end
		if (n_push == 2'd2) begin
			entry_q[wr_next] <= push.summary_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + tls_sni_pkg::QUEUE_AW'(n_push);
			rd_q    <= rd_q + tls_sni_pkg::QUEUE_AW'(pop);
			count_q <= count_q + (tls_sni_pkg::QUEUE_AW + 1)'(n_push)
				- (tls_sni_pkg::QUEUE_AW + 1)'(pop);
		end
	end

endmodule

@@ src/tls_sni_client_hello_sni_extractor.sv @@
// Takes one TLS payload byte per request and can accept a byte on every clock while
// byte_stall is low. Each byte is registered, parsed combinationally, and any results
// (a server name byte, and a summary on the last byte of the packet) enter a four-entry
// result queue, which drives the result channel one request per cycle while result_stall
// is low. The byte channel stalls only while the queue holds more than two results, so
// the sustained rate is one byte per cycle whenever results are taken promptly.
module tls_client_hello_sni_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic [15:0] packet_length,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        item_kind,
	output logic [7:0]  name_byte,
	output logic        name_end,
	output logic [1:0]  record_class,
	output logic [15:0] app_record_length,
	output logic        sni_found,
	output logic [15:0] sni_length
);

	tls_sni_pkg::push_t   push;
	tls_sni_pkg::result_t head;
	logic                 push_ready;

	tls_sni_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.packet_length (packet_length),
		.last_byte     (last_byte),
		.push_ready    (push_ready),
		.push          (push)
	);

	tls_sni_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head_valid (result_valid),
		.head_stall (result_stall),
		.head       (head)
	);

	assign item_kind         = head.item_kind;
	assign name_byte         = head.name_byte;
	assign name_end          = head.name_end;
	assign record_class      = head.record_class;
	assign app_record_length = head.app_record_length;
	assign sni_found         = head.sni_found;
	assign sni_length        = head.sni_length;

endmodule

@@ verif/tb_tls_client_hello_sni_extractor.sv @@
module tb_tls_client_hello_sni_extractor;
	import tls_sni_pkg::*;

	localparam int unsigned HS_TYPE_POS   = 5;
	localparam int unsigned APP_LEN_POS   = 3;
	localparam int unsigned RANDOM_ITEMS  = 100;
	localparam int unsigned DRAIN_CYCLES  = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'h00;
	logic [15:0] packet_length = 16'h0000;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        item_kind;
	logic [7:0]  name_byte;
	logic        name_end;
	logic [1:0]  record_class;
	logic [15:0] app_record_length;
	logic        sni_found;
	logic [15:0] sni_length;

	tls_client_hello_sni_extractor dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.byte_valid        (byte_valid),
		.byte_stall        (byte_stall),
		.data_byte         (data_byte),
		.packet_length     (packet_length),
		.last_byte         (last_byte),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.item_kind         (item_kind),
		.name_byte         (name_byte),
		.name_end          (name_end),
		.record_class      (record_class),
		.app_record_length (app_record_length),
		.sni_found         (sni_found),
		.sni_length        (sni_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser state of the predictor
	int unsigned pos_cnt, hold_len, skip_cnt, ext_end, acc, ext_type, name_left;
	int unsigned rec_len, name_len;
	logic [4:0]  phase = PH_IDLE;
	logic [1:0]  cls;
	logic        found;

	result_t     expected_results[$];
	result_t     want_r;
	logic [7:0]  pkt_bytes[$];
	int unsigned name_at;
	int unsigned errors = 0;
	int unsigned results_seen = 0;
	int unsigned burst_left = 0;
	int unsigned random_sent;
	int unsigned stall_mode = 0;
	int unsigned mode_left = 0;
	int unsigned stall_tick = 0;

	function automatic void advance_to(int unsigned pos, int unsigned p, int unsigned need,
			int unsigned bound, logic [4:0] ph);
		if (p + need > bound) begin
			phase = PH_OFF;
		end else begin
			skip_cnt = (p - (pos + 1)) & 32'hFFFF;
			phase = ph;
		end
	endfunction

	task automatic predict_sni_byte(input logic [7:0] d, input logic [15:0] len, input logic last);
		int unsigned pos, p, v, e, nl;
		result_t r;
		if (phase == PH_IDLE) begin
			hold_len = len;
			cls = CLASS_NONE;
			rec_len = 0;
			found = 1'b0;
			name_len = 0;
			skip_cnt = 0;
			name_left = 0;
			phase = PH_OFF;
			if (len >= MIN_RECORD_LEN) begin
				if (d == CT_HANDSHAKE) begin
					cls = CLASS_HS;
					if (len > HS_BODY_POS)
						advance_to(0, HS_TYPE_POS, 1, hold_len, PH_HST);
				end else if (d == CT_APPDATA) begin
					cls = CLASS_APP;
					advance_to(0, APP_LEN_POS, 2, hold_len, PH_APP_HI);
				end
			end
			pos_cnt = 1;
		end else begin
			pos = pos_cnt;
			if (phase != PH_OFF && pos < hold_len) begin
				if (skip_cnt > 0) begin
					skip_cnt--;
				end else begin
					p = pos + 1;
					v = ((acc << 8) | d) & 32'hFFFF;
					case (phase)
						PH_APP_HI: begin
							acc = d;
							phase = PH_APP_LO;
						end
						PH_APP_LO: begin
							rec_len = v;
							phase = PH_OFF;
						end
						PH_HST: begin
							if (d == HS_CLIENT_HELLO)
								advance_to(pos, int'(SID_POS), 1, hold_len, PH_SID);
							else
								phase = PH_OFF;
						end
						PH_SID: advance_to(pos, p + d, 2, hold_len, PH_CS_HI);
						PH_CS_HI: begin
							acc = d;
							phase = PH_CS_LO;
						end
						PH_CS_LO: advance_to(pos, p + v, 1, hold_len, PH_CM);
						PH_CM: advance_to(pos, p + d, 2, hold_len, PH_EXL_HI);
						PH_EXL_HI: begin
							acc = d;
							phase = PH_EXL_LO;
						end
						PH_EXL_LO: begin
							e = p + v;
							ext_end = (e > hold_len) ? hold_len : e;
							advance_to(pos, p, 4, ext_end, PH_ET_HI);
						end
						PH_ET_HI: begin
							acc = d;
							phase = PH_ET_LO;
						end
						PH_ET_LO: begin
							ext_type = v;
							phase = PH_EL_HI;
						end
						PH_EL_HI: begin
							acc = d;
							phase = PH_EL_LO;
						end
						PH_EL_LO: begin
							if (ext_type == 0)
								advance_to(pos, p + 2, 1, ext_end, PH_NTYPE);
							else
								advance_to(pos, p + v, 4, ext_end, PH_ET_HI);
						end
						PH_NTYPE: begin
							if (d == 8'h00)
								advance_to(pos, p, 2, ext_end, PH_NL_HI);
							else
								advance_to(pos, p, 4, ext_end, PH_ET_HI);
						end
						PH_NL_HI: begin
							acc = d;
							phase = PH_NL_LO;
						end
						PH_NL_LO: begin
							nl = v;
							if (p + nl <= ext_end) begin
								if (nl == 0) begin
									phase = PH_OFF;
								end else begin
									name_left = nl;
									name_len = nl;
									skip_cnt = 0;
									phase = PH_NAME;
								end
							end else begin
								advance_to(pos, p, 4, ext_end, PH_ET_HI);
							end
						end
						PH_NAME: begin
							name_left = (name_left - 1) & 32'hFFFF;
							r = '0;
							r.item_kind = KIND_NAME;
							r.name_byte = d;
							if (name_left == 0) begin
								found = 1'b1;
								phase = PH_OFF;
								r.name_end = 1'b1;
							end
							expected_results.push_back(r);
						end
						default: phase = PH_OFF;
					endcase
				end
			end
			if (pos_cnt < 32'hFFFF)
				pos_cnt++;
		end
		if (last) begin
			r = '0;
			r.item_kind = KIND_SUMMARY;
			r.record_class = cls;
			r.app_record_length = (cls == CLASS_APP) ? rec_len[15:0] : 16'h0000;
			r.sni_found = found;
			r.sni_length = found ? name_len[15:0] : 16'h0000;
			expected_results.push_back(r);
			phase = PH_IDLE;
			pos_cnt = 0;
		end
	endtask

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		errors++;
		if (errors < 100)
			$display("mismatch in result %0d, %s: got %h, expected %h", results_seen, what,
				got, want);
	endtask

	task automatic check_field(string fname, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch(fname, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", {15'h0, item_kind}, 16'h0);
			end else begin
				want_r = expected_results.pop_front();
				check_field("item_kind", item_kind, want_r.item_kind);
				check_field("name_byte", name_byte, want_r.name_byte);
				check_field("name_end", name_end, want_r.name_end);
				check_field("record_class", record_class, want_r.record_class);
				check_field("app_record_length", app_record_length, want_r.app_record_length);
				check_field("sni_found", sni_found, want_r.sni_found);
				check_field("sni_length", sni_length, want_r.sni_length);
			end
			results_seen++;
		end
	end

	// result side back-pressure: modes of random length
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		stall_tick++;
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 9) < 3);
			2: result_stall <= ($urandom_range(0, 9) < 7);
			default: result_stall <= ((stall_tick % 5) < 2);
		endcase
	end

	task automatic send_byte(input logic [7:0] d, input logic [15:0] len, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				byte_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		byte_valid <= 1'b1;
		data_byte <= d;
		packet_length <= len;
		last_byte <= last;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		predict_sni_byte(d, len, last);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_packet(input logic [15:0] len);
		for (int i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], (i == 0) ? len : 16'($urandom), i == pkt_bytes.size() - 1);
	endtask

	task automatic wait_results_drained();
		byte_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic void push_u16(int unsigned w);
		pkt_bytes.push_back(8'(w >> 8));
		pkt_bytes.push_back(8'(w));
	endfunction

	function automatic void push_random(int unsigned n);
		repeat (n) pkt_bytes.push_back(8'($urandom));
	endfunction

	// ClientHello with random content; claim_len is what the name length field says
	task automatic make_hello(int unsigned sid_len, int unsigned cs_len, int unsigned cm_len,
			int unsigned pre_exts, logic [7:0] name_type, int unsigned nlen,
			int unsigned claim_len);
		int unsigned ext_start, el, sz;
		pkt_bytes.delete();
		pkt_bytes.push_back(CT_HANDSHAKE);
		push_u16(16'h0301);
		push_u16(0);
		pkt_bytes.push_back(HS_CLIENT_HELLO);
		pkt_bytes.push_back(8'h00);
		push_u16(0);
		push_u16(16'h0303);
		push_random(32);
		pkt_bytes.push_back(8'(sid_len));
		push_random(sid_len);
		push_u16(cs_len);
		push_random(cs_len);
		pkt_bytes.push_back(8'(cm_len));
		push_random(cm_len);
		push_u16(0);
		ext_start = pkt_bytes.size();
		repeat (pre_exts) begin
			el = $urandom_range(0, 6);
			push_u16($urandom_range(1, 65535));
			push_u16(el);
			push_random(el);
		end
		push_u16(0);
		push_u16(nlen + 5);
		push_u16(nlen + 3);
		pkt_bytes.push_back(name_type);
		push_u16(claim_len);
		name_at = pkt_bytes.size();
		push_random(nlen);
		if ($urandom_range(0, 1) != 0) begin
			push_u16(16'h0010);
			push_u16(2);
			push_random(2);
		end
		sz = pkt_bytes.size();
		pkt_bytes[ext_start - 2] = 8'((sz - ext_start) >> 8);
		pkt_bytes[ext_start - 1] = 8'(sz - ext_start);
		pkt_bytes[3] = 8'((sz - 5) >> 8);
		pkt_bytes[4] = 8'(sz - 5);
		pkt_bytes[7] = 8'((sz - 9) >> 8);
		pkt_bytes[8] = 8'(sz - 9);
	endtask

	task automatic make_random_hello();
		int unsigned n;
		n = $urandom_range(1, 16);
		make_hello($urandom_range(0, 8), 2 * $urandom_range(1, 4), $urandom_range(1, 3),
			$urandom_range(0, 3), 8'h00, n, n);
	endtask

	task automatic test_short_packets();
		pkt_bytes = '{CT_HANDSHAKE};
		send_packet(16'h0000);
		pkt_bytes = '{8'hFF};
		send_packet(16'hFFFF);
		pkt_bytes = '{CT_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'h01};
		send_packet(16'd5);
		pkt_bytes = '{CT_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'h01, HS_CLIENT_HELLO};
		send_packet(16'd6);
		pkt_bytes = '{CT_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'h05, HS_CLIENT_HELLO,
			8'h00, 8'h00, 8'h01, 8'h03};
		send_packet(16'd10);
		pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_packet(16'd6);
	endtask

	task automatic test_app_data();
		pkt_bytes = '{CT_APPDATA, 8'h03, 8'h03, 8'hFF, 8'hFF, 8'h00};
		send_packet(16'd6);
		pkt_bytes = '{CT_APPDATA, 8'h03, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00};
		send_packet(16'd7);
		pkt_bytes = '{CT_APPDATA, 8'h03, 8'h03, 8'h12};
		send_packet(16'd6);
		pkt_bytes = '{CT_APPDATA, 8'h03, 8'h03, 8'h01, 8'h02};
		send_packet(16'd5);
	endtask

	task automatic test_client_hello();
		make_hello(32, 4, 1, 2, 8'h00, 16, 16);
		send_packet(16'(pkt_bytes.size()));
		make_hello(0, 2, 1, 0, 8'h00, 1, 1);
		pkt_bytes[name_at] = 8'hFF;
		send_packet(16'(pkt_bytes.size()));
		make_hello(1, 2, 1, 1, 8'h00, 2, 2);
		pkt_bytes[name_at] = 8'h00;
		send_packet(16'(pkt_bytes.size()));
		// handshake but not a ClientHello
		make_hello(0, 2, 1, 0, 8'h00, 4, 4);
		pkt_bytes[HS_TYPE_POS] = 8'h02;
		send_packet(16'(pkt_bytes.size()));
	endtask

	task automatic test_name_cases();
		make_hello(0, 2, 1, 1, 8'h01, 6, 6);
		send_packet(16'(pkt_bytes.size()));
		make_hello(2, 4, 1, 0, 8'h00, 6, 40);
		send_packet(16'(pkt_bytes.size()));
		make_hello(0, 2, 1, 0, 8'h00, 0, 0);
		send_packet(16'(pkt_bytes.size()));
	endtask

	task automatic test_packet_bounds();
		int unsigned sz;
		// ends in the middle of the name
		make_hello(0, 2, 1, 0, 8'h00, 10, 10);
		sz = pkt_bytes.size();
		while (pkt_bytes.size() > name_at + 5)
			void'(pkt_bytes.pop_back());
		send_packet(16'(sz));
		// length field cuts the name off
		make_hello(0, 2, 1, 0, 8'h00, 10, 10);
		send_packet(16'(name_at + 3));
		// trailing bytes beyond the stated length
		make_hello(1, 2, 2, 1, 8'h00, 5, 5);
		sz = pkt_bytes.size();
		push_random(10);
		send_packet(16'(sz));
	endtask

	task automatic test_random_traffic();
		int unsigned pick, sz;
		logic [15:0] len;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				make_random_hello();
				len = 16'(pkt_bytes.size());
			end else if (pick < 65) begin
				sz = $urandom_range(1, 12);
				case ($urandom_range(0, 2))
					0: make_hello($urandom_range(0, 4), 2, 1, $urandom_range(0, 2),
						8'($urandom_range(1, 255)), sz, sz);
					1: make_hello($urandom_range(0, 4), 2, 1, $urandom_range(0, 2), 8'h00,
						sz, sz + $urandom_range(7, 60));
					default: make_hello($urandom_range(0, 4), 2, 1, $urandom_range(0, 2),
						8'h00, 0, 0);
				endcase
				len = 16'(pkt_bytes.size());
			end else if (pick < 75) begin
				make_random_hello();
				sz = pkt_bytes.size();
				len = 16'(sz);
				case ($urandom_range(0, 3))
					0: begin
						repeat ($urandom_range(1, sz - 1)) void'(pkt_bytes.pop_back());
					end
					1: len = 16'($urandom_range(0, sz));
					2: push_random($urandom_range(1, 8));
					default: pkt_bytes[$urandom_range(0, sz - 1)] = 8'($urandom);
				endcase
			end else if (pick < 85) begin
				pkt_bytes.delete();
				pkt_bytes.push_back(CT_APPDATA);
				push_random($urandom_range(0, 11));
				len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(pkt_bytes.size());
			end else begin
				pkt_bytes.delete();
				push_random($urandom_range(1, 10));
				if ($urandom_range(0, 2) == 0)
					pkt_bytes[0] = CT_HANDSHAKE;
				if (pkt_bytes.size() > HS_TYPE_POS && $urandom_range(0, 1) == 0)
					pkt_bytes[HS_TYPE_POS] = HS_CLIENT_HELLO;
				len = 16'($urandom);
			end
			send_packet(len);
			random_sent += pkt_bytes.size();
			if ($urandom_range(0, 19) == 0)
				wait_results_drained();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_short_packets();
		wait_results_drained();
		test_app_data();
		wait_results_drained();
		test_client_hello();
		wait_results_drained();
		test_name_cases();
		wait_results_drained();
		test_packet_bounds();
		wait_results_drained();
		test_random_traffic();
		wait_results_drained();
		if (errors == 0)
			$display("** tls_client_hello_sni_extractor: PASSED **");
		else
			$display("** tls_client_hello_sni_extractor: FAILED **");
		$finish;
	end

	initial begin
		#40000000;
		$display("** tls_client_hello_sni_extractor: FAILED **");
		$finish;
	end

endmodule

@@ tls_client_hello_sni_extractor.f @@
src/tls_sni_pkg.sv
src/tls_sni_parser.sv
src/tls_sni_result_queue.sv
src/tls_sni_client_hello_sni_extractor.sv
verif/tb_tls_client_hello_sni_extractor.sv
